@@ hdl/periodic_task_dispatcher_unit_assert.svh @@
// Assertion macros for the periodic task dispatcher.
// Needs clk and rst in the scope where a macro is used.
`ifndef PERIODIC_TASK_DISPATCHER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher check failed");

// Next-cycle implication, disabled during reset.
`define PTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher check failed");

`endif

@@ hdl/ptd_pkg.sv @@
// Shared types, codes and defaults for the periodic task dispatcher.
// No dependencies; used by every module in hdl.
package ptd_pkg;

  localparam int DEF_NUM_SLOTS = 8;
  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 16;

  // Command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;

  // Event codes
  localparam logic [2:0] EV_DISPATCHED = 3'd0;
  localparam logic [2:0] EV_RESUMED    = 3'd1;
  localparam logic [2:0] EV_IDLE       = 3'd2;
  localparam logic [2:0] EV_ADDED      = 3'd3;
  localparam logic [2:0] EV_FULL       = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] start_delay;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [SLOT_W-1:0] slot;
  } evt_word_t;

  // Broadcast from the top level to every slot cell
  typedef struct packed {
    logic              tick;
    logic              add;
    logic              done;
    logic              scan;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] delay;
  } cell_ctl_t;

  // Priority flags rippled from cell to cell
  typedef struct packed {
    logic free_seen;
    logic rdy_seen;
  } chain_t;

  // Run stack operation
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

endpackage

@@ hdl/ptd_cell.sv @@
// One task slot cell: valid, period, countdown and ready mark.
// Depends on ptd_pkg; chained by periodic_task_dispatcher_unit.
module ptd_cell #(
  parameter int IDX_W     = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  ptd_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]  pop_slot,
  input  logic [IDX_W-1:0]  limit,
  input  ptd_pkg::chain_t   chain_in,
  input  logic [IDX_W-1:0]  free_idx_in,
  input  logic [IDX_W-1:0]  rdy_idx_in,
  output ptd_pkg::chain_t   chain_out,
  output logic [IDX_W-1:0]  free_idx_out,
  output logic [IDX_W-1:0]  rdy_idx_out
);
  import ptd_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              valid, ready;
  logic [TIME_W-1:0] period, countdown;
  logic              valid_next, ready_next;
  logic [TIME_W-1:0] period_next, countdown_next;

  logic expire, freed, valid_eff, rdy_eff, eligible, claim, add_claim;

  // Effect of this word on the slot before the priority pick
  assign expire    = ctl.tick & valid & (countdown == '0);
  assign freed     = ctl.done & (pop_slot == MY_IDX) & (period == '0);
  assign valid_eff = valid & ~freed;
  assign rdy_eff   = (ready | expire) & ~freed;
  assign eligible  = ctl.scan & valid_eff & rdy_eff & (MY_IDX < limit);
  assign claim     = eligible & ~chain_in.rdy_seen;
  assign add_claim = ctl.add & ~valid & ~chain_in.free_seen;

  // Priority chain toward higher indexes
  assign chain_out.free_seen = chain_in.free_seen | ~valid;
  assign chain_out.rdy_seen  = chain_in.rdy_seen | eligible;
  assign free_idx_out = (chain_in.free_seen || valid) ? free_idx_in : MY_IDX;
  assign rdy_idx_out  = (chain_in.rdy_seen || !eligible) ? rdy_idx_in : MY_IDX;

  // Next slot contents
  always_comb begin
    valid_next     = add_claim | valid_eff;
    ready_next     = rdy_eff & ~claim & ~add_claim;
    period_next    = add_claim ? ctl.period : period;
    countdown_next = countdown;
    if (add_claim) begin
      countdown_next = ctl.delay;
    end else if (ctl.tick && valid) begin
      countdown_next = (countdown != '0) ? countdown - 1'b1 : period - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      ready     <= 1'b0;
      period    <= '0;
      countdown <= '0;
    end else begin
      valid     <= valid_next;
      ready     <= ready_next;
      period    <= period_next;
      countdown <= countdown_next;
    end
  end

endmodule

@@ hdl/ptd_stack.sv @@
// Preemption stack as a shift line: entry 0 is the running task.
// Depends on ptd_pkg; used by periodic_task_dispatcher_unit.
module ptd_stack #(
  parameter int NUM_SLOTS = 8,
  parameter int IDX_W     = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ptd_pkg::stack_ctl_t op,
  input  logic [IDX_W-1:0]    push_slot,
  output logic [IDX_W-1:0]    run_slot,
  output logic [IDX_W-1:0]    prev_slot,
  output logic [IDX_W-1:0]    depth
);
  import ptd_pkg::*;

  localparam logic [IDX_W-1:0] NONE = IDX_W'(NUM_SLOTS);

  logic [IDX_W-1:0] stk [NUM_SLOTS];

  // Entries hold no reset; only entries below depth are read
  always_ff @(posedge clk) begin
    if (op.push) begin
      stk[0] <= push_slot;
      if (!op.pop) begin
        for (int i = 1; i < NUM_SLOTS; i++) begin
          stk[i] <= stk[i-1];
        end
      end
    end else if (op.pop) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (op.push && !op.pop) begin
      depth <= depth + 1'b1;
    end else if (op.pop && !op.push) begin
      depth <= depth - 1'b1;
    end
  end

  assign run_slot  = (depth == '0) ? NONE : stk[0];
  assign prev_slot = (depth > IDX_W'(1)) ? stk[1] : NONE;

endmodule

@@ hdl/periodic_task_dispatcher_unit.sv @@
// Periodic task dispatcher: a chain of slot cells plus a preemption stack.
// The event word is registered and appears in the cycle after the command word is taken.
// Throughput: one command per cycle unless the event output is stalled; the cell chain and stack settle in one pass.
// Reset (rst, synchronous): all slots empty, nothing running, output empty.
// Depends on ptd_pkg, ptd_cell, ptd_stack and the assertion macro header.
module periodic_task_dispatcher_unit #(
  parameter int NUM_SLOTS = ptd_pkg::DEF_NUM_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ptd_pkg::cmd_word_t cmd_data,
  output logic               evt_valid,
  input  logic               evt_ready,
  output ptd_pkg::evt_word_t evt_data
);
  import ptd_pkg::*;
  `include "periodic_task_dispatcher_unit_assert.svh"

  localparam int IDX_W = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] NONE = IDX_W'(NUM_SLOTS);

  logic             fire, is_add, is_tick, is_done, busy, full;
  cell_ctl_t        ctl;
  stack_ctl_t       stk_op;
  logic [IDX_W-1:0] run_slot, prev_slot, depth, limit;
  chain_t           chain    [NUM_SLOTS+1];
  logic [IDX_W-1:0] free_idx [NUM_SLOTS+1];
  logic [IDX_W-1:0] rdy_idx  [NUM_SLOTS+1];
  logic [2:0]       ev;
  logic [IDX_W-1:0] sl;

  // Handshake: output register frees the input side
  assign cmd_ready = ~evt_valid | evt_ready;
  assign fire      = cmd_valid & cmd_ready;

  // Command decode
  assign is_add  = (cmd_data.cmd == CMD_ADD);
  assign is_tick = (cmd_data.cmd == CMD_TICK);
  assign is_done = (cmd_data.cmd == CMD_DONE);
  assign busy    = (depth != '0);
  assign full    = (depth == NONE);

  assign ctl.tick   = fire & is_tick;
  assign ctl.add    = fire & is_add;
  assign ctl.done   = fire & is_done & busy;
  assign ctl.scan   = fire & ((is_tick & ~full) | (is_done & busy));
  assign ctl.period = cmd_data.period;
  assign ctl.delay  = cmd_data.start_delay;

  // After a pop the preempted task bounds the pick
  assign limit = is_done ? prev_slot : run_slot;

  // Cell chain
  assign chain[0]    = '0;
  assign free_idx[0] = NONE;
  assign rdy_idx[0]  = NONE;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ptd_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .pop_slot    (run_slot),
      .limit       (limit),
      .chain_in    (chain[g]),
      .free_idx_in (free_idx[g]),
      .rdy_idx_in  (rdy_idx[g]),
      .chain_out   (chain[g+1]),
      .free_idx_out(free_idx[g+1]),
      .rdy_idx_out (rdy_idx[g+1])
    );
  end

  // Preemption stack
  assign stk_op.push = chain[NUM_SLOTS].rdy_seen;
  assign stk_op.pop  = ctl.done;

  ptd_stack #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .op       (stk_op),
    .push_slot(rdy_idx[NUM_SLOTS]),
    .run_slot (run_slot),
    .prev_slot(prev_slot),
    .depth    (depth)
  );

  // Event selection
  always_comb begin
    ev = EV_IDLE;
    sl = run_slot;
    case (cmd_data.cmd)
      CMD_ADD: begin
        if (chain[NUM_SLOTS].free_seen) begin
          ev = EV_ADDED;
          sl = free_idx[NUM_SLOTS];
        end else begin
          ev = EV_FULL;
          sl = NONE;
        end
      end
      CMD_TICK: begin
        if (chain[NUM_SLOTS].rdy_seen) begin
          ev = EV_DISPATCHED;
          sl = rdy_idx[NUM_SLOTS];
        end
      end
      CMD_DONE: begin
        if (chain[NUM_SLOTS].rdy_seen) begin
          ev = EV_DISPATCHED;
          sl = rdy_idx[NUM_SLOTS];
        end else if (busy && prev_slot != NONE) begin
          ev = EV_RESUMED;
          sl = prev_slot;
        end else begin
          ev = EV_IDLE;
          sl = NONE;
        end
      end
      default: begin
        ev = EV_IDLE;
        sl = run_slot;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (fire) begin
      evt_valid <= 1'b1;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      evt_data.event_res <= ev;
      evt_data.slot      <= SLOT_W'(sl);
    end
  end

  // Checks
  `PTD_ASSERT_NOW(a_depth_bound, 1'b1, depth <= NONE)
  `PTD_ASSERT_NEXT(a_tick_push, ctl.tick && stk_op.push, depth == $past(depth) + 1'b1)
  `PTD_ASSERT_NEXT(a_idle_done, fire && is_done && !busy, depth == '0)
  `PTD_ASSERT_NOW(a_push_bound, stk_op.push, rdy_idx[NUM_SLOTS] < limit)

endmodule

@@ sim/tb_periodic_task_dispatcher_unit.sv @@
// Self-checking testbench for periodic_task_dispatcher_unit: directed and random command
// words, with an in-bench slot table and preemption stack predicting every event word.
// Depends on hdl/ptd_pkg.sv and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_unit;
  import ptd_pkg::*;

  localparam int NUM_SLOTS = DEF_NUM_SLOTS;
  // cmd value 3 has no meaning; the block must answer it without changing state
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum {RX_ALWAYS, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_word_t cmd_data = '0;
  logic      evt_valid;
  logic      evt_ready = 1'b0;
  evt_word_t evt_data;

  // Slot table and preemption stack as the block should hold them
  bit                slot_valid [NUM_SLOTS];
  logic [TIME_W-1:0] slot_period [NUM_SLOTS];
  logic [TIME_W-1:0] slot_countdown [NUM_SLOTS];
  bit                slot_ready [NUM_SLOTS];
  int                run_stack [NUM_SLOTS];
  int                run_depth;

  evt_word_t pending_events[$];
  int        err_cnt = 0;

  // Sender burst state, receiver stall state
  int       burst_left = 0;
  bit       steady_send = 1'b0;
  bit       hold_off_req = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_phase = 0;
  rx_mode_t rx_mode = RX_ALWAYS;

  periodic_task_dispatcher_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt_data (evt_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int running_task();
    return (run_depth == 0) ? NUM_SLOTS : run_stack[run_depth-1];
  endfunction

  // Highest-priority ready slot above the running task gets pushed
  function automatic bit preempt_pick(output int chosen);
    int limit;
    limit = running_task();
    chosen = NUM_SLOTS;
    for (int i = 0; i < limit; i++) begin
      if (slot_valid[i] && slot_ready[i]) begin
        if (run_depth >= NUM_SLOTS) return 1'b0;
        slot_ready[i] = 1'b0;
        run_stack[run_depth] = i;
        run_depth++;
        chosen = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic evt_word_t predict_event(cmd_word_t w);
    evt_word_t r;
    int        s;
    bit        placed;
    placed = 1'b0;
    r.event_res = EV_IDLE;
    r.slot = SLOT_W'(running_task());
    case (w.cmd)
      CMD_ADD: begin
        r.event_res = EV_FULL;
        r.slot = SLOT_W'(NUM_SLOTS);
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !slot_valid[i]) begin
            placed = 1'b1;
            slot_valid[i] = 1'b1;
            slot_period[i] = w.period;
            slot_countdown[i] = w.start_delay;
            slot_ready[i] = 1'b0;
            r.event_res = EV_ADDED;
            r.slot = SLOT_W'(i);
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_valid[i]) begin
            if (slot_countdown[i] != '0) begin
              slot_countdown[i] = slot_countdown[i] - 1'b1;
            end else begin
              slot_ready[i] = 1'b1;
              slot_countdown[i] = slot_period[i] - 1'b1;
            end
          end
        end
        if (preempt_pick(s)) begin
          r.event_res = EV_DISPATCHED;
          r.slot = SLOT_W'(s);
        end else begin
          r.slot = SLOT_W'(running_task());
        end
      end
      CMD_DONE: begin
        if (run_depth != 0) begin
          run_depth--;
          s = run_stack[run_depth];
          // one-shot tasks leave the table when they finish
          if (slot_period[s] == '0) begin
            slot_valid[s] = 1'b0;
            slot_ready[s] = 1'b0;
          end
          if (preempt_pick(s)) begin
            r.event_res = EV_DISPATCHED;
            r.slot = SLOT_W'(s);
          end else if (run_depth > 0) begin
            r.event_res = EV_RESUMED;
            r.slot = SLOT_W'(running_task());
          end else begin
            r.slot = SLOT_W'(NUM_SLOTS);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic cmd_word_t make_word(logic [1:0] c, logic [TIME_W-1:0] p,
                                          logic [TIME_W-1:0] d);
    cmd_word_t w;
    w.cmd = c;
    w.period = p;
    w.start_delay = d;
    return w;
  endfunction

  // Mostly sensible traffic: short one-shots, a few periodic tasks, ticks and
  // completions; full-range fields ride on words that ignore them.
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        pick;
    int        free_cnt;
    int        periodic_cnt;
    free_cnt = 0;
    periodic_cnt = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!slot_valid[i]) free_cnt++;
      else if (slot_period[i] != '0) periodic_cnt++;
    end
    w.period = TIME_W'($urandom);
    w.start_delay = TIME_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      w.cmd = CMD_UNUSED;
    end else if (pick < 40) begin
      w.cmd = CMD_TICK;
    end else if (pick < 70 && (run_depth != 0 || pick < 44)) begin
      w.cmd = CMD_DONE;
    end else begin
      w.cmd = CMD_ADD;
      if (free_cnt != 0) begin
        if (periodic_cnt < 3 && $urandom_range(0, 4) == 0) begin
          w.period = TIME_W'($urandom_range(1, 12));
          w.start_delay = TIME_W'($urandom_range(0, 6));
        end else begin
          w.period = '0;
          w.start_delay = TIME_W'($urandom_range(0, 8));
        end
      end
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then log its expected event
  task automatic send_word(input cmd_word_t w);
    if (burst_left == 0 && !steady_send) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    cmd_valid <= 1'b1;
    cmd_data  <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_events.push_back(predict_event(w));
  endtask

  task automatic test_idle_cases();
    send_word(make_word(CMD_DONE, 16'h0000, 16'h0000));
    send_word(make_word(CMD_UNUSED, 16'hffff, 16'hffff));
    send_word(make_word(CMD_TICK, 16'h0000, 16'hffff));
  endtask

  // Dispatch, no preemption by a lower priority, preemption, resume, idle
  task automatic test_preemption();
    send_word(make_word(CMD_ADD, 16'd0, 16'd0));
    send_word(make_word(CMD_ADD, 16'd0, 16'd2));
    send_word(make_word(CMD_TICK, 16'd0, 16'd0));
    send_word(make_word(CMD_TICK, 16'd0, 16'd0));
    send_word(make_word(CMD_UNUSED, 16'd0, 16'd0));
    send_word(make_word(CMD_TICK, 16'd0, 16'd0));
    send_word(make_word(CMD_DONE, 16'd0, 16'd0));
    send_word(make_word(CMD_ADD, 16'd0, 16'd0));
    send_word(make_word(CMD_TICK, 16'd0, 16'd0));
    send_word(make_word(CMD_DONE, 16'd0, 16'd0));
    send_word(make_word(CMD_DONE, 16'd0, 16'd0));
  endtask

  // Fill every slot, then overflow with all-ones fields
  task automatic test_table_full();
    for (int i = 0; i < NUM_SLOTS - 1; i++)
      send_word(make_word(CMD_ADD, 16'd0, TIME_W'(i)));
    send_word(make_word(CMD_ADD, 16'hffff, 16'h0000));
    send_word(make_word(CMD_ADD, 16'hffff, 16'hffff));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  // Long receiver hold-off while words keep coming without gaps
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    steady_send = 1'b1;
    test_random_traffic(30);
    steady_send = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_left = 160;
      hold_off_req = 1'b0;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      evt_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: evt_ready <= 1'b1;
        RX_COIN:   evt_ready <= 1'($urandom_range(0, 1));
        RX_THIRD:  evt_ready <= (rx_phase % 3 == 0);
        default:   evt_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : event_check
    evt_word_t want;
    if (!rst && evt_valid && evt_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event word: expected none, actual event_res=%0d slot=%0d",
                 $time, evt_data.event_res, evt_data.slot);
        err_cnt++;
      end else begin
        want = pending_events.pop_front();
        if (evt_data.event_res !== want.event_res) begin
          $display("%0t: event_res mismatch: expected %0d, actual %0d",
                   $time, want.event_res, evt_data.event_res);
          err_cnt++;
        end
        if (evt_data.slot !== want.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, want.slot, evt_data.slot);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    run_depth = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_period[i] = '0;
      slot_countdown[i] = '0;
      slot_ready[i] = 1'b0;
      run_stack[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_idle_cases();
    test_preemption();
    test_table_full();
    test_random_traffic(200);
    test_backpressure();
    test_random_traffic(220);

    cmd_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ptd_pkg.sv
hdl/ptd_cell.sv
hdl/ptd_stack.sv
hdl/periodic_task_dispatcher_unit.sv
sim/tb_periodic_task_dispatcher_unit.sv
